### rtl/pft_pkg.sv
// Shared types and constants for the trial-division prime factorizer.
`default_nettype none
package pft_pkg;

  // Width of the factor field on the result channel.
  localparam int FACTOR_W = 16;
  // Most results one input item may produce.
  localparam int MAX_RESULTS = 16;
  // Width of the emitted-result counter.
  localparam int CNT_W = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_SEND
  } pft_state_t;

endpackage
`default_nettype wire

### rtl/pft_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module pft_div #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  div_r, div_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  // One step: shift the next dividend bit into the partial remainder and
  // subtract the divisor where it fits.
  assign shifted = {rem_r, quo_r[W-1]};
  assign ge      = shifted >= {1'b0, div_r};
  assign diff    = shifted - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

### rtl/prime_factorize_trial_division_top.sv
// Top level of the trial-division prime factorizer: sequencer and result register.
// Each trial divisor takes a pass through the test state plus a run of the shared
// bit-serial divider; a 16-bit prime tries 254 divisors.
// Each result waits in the send state for out_tready; inputs 0 and 1 skip the
// trials. One item is handled at a time; in_tready is low meanwhile.
// rst_n is synchronous and active low; it returns the sequencer to idle.
`default_nettype none
module prime_factorize_trial_division_top #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // in_tdata: value [VALUE_WIDTH-1:0], zero padding above to a whole byte.
  input  wire logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // out_tdata: factor [15:0].
  output logic [pft_pkg::FACTOR_W-1:0]               out_tdata,
  output logic                                       out_tlast,
  // out_tuser: invalid [0].
  output logic                                       out_tuser
);

  localparam int VW = VALUE_WIDTH;
  localparam int FW = pft_pkg::FACTOR_W;

  pft_pkg::pft_state_t state_r, state_nxt;

  logic [VW-1:0]               rest_r, rest_nxt;   // value still to be factored
  logic [VW-1:0]               d_r, d_nxt;         // current trial divisor
  logic [VW:0]                 sq_r, sq_nxt;       // d_r squared, kept by adds
  logic [pft_pkg::CNT_W-1:0]   n_r, n_nxt;         // results emitted so far
  logic [FW-1:0]               factor_r, factor_nxt;
  logic                        last_r, last_nxt;
  logic                        invalid_r, invalid_nxt;

  logic          in_acc;
  logic          small_in;
  logic          sq_le;
  logic          div_start;
  logic          div_done;
  logic [VW-1:0] div_quo;
  logic [VW-1:0] div_rem;
  logic          rem_zero;
  logic [FW+VW-1:0] rest_ext;
  logic [FW+VW-1:0] d_ext;

  assign in_acc   = in_tvalid && in_tready;
  // Values zero and one have no factors and are flagged invalid.
  assign small_in = (in_tdata[VW-1:1] == '0);
  // The trial loop keeps going while the divisor squared fits in the rest.
  assign sq_le    = sq_r <= {1'b0, rest_r};
  assign rem_zero = (div_rem == '0);
  // Factors leave as 16 bits; wider values are cut, narrower ones padded.
  assign rest_ext = {{FW{1'b0}}, rest_r};
  assign d_ext    = {{FW{1'b0}}, d_r};

  // The one shared divider computes rest / d for every trial.
  pft_div #(
    .W(VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rest_r),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pft_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = small_in ? pft_pkg::ST_SEND : pft_pkg::ST_TEST;
        end
      end
      pft_pkg::ST_TEST: begin
        state_nxt = sq_le ? pft_pkg::ST_DIV : pft_pkg::ST_SEND;
      end
      pft_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = rem_zero ? pft_pkg::ST_SEND : pft_pkg::ST_TEST;
        end
      end
      pft_pkg::ST_SEND: begin
        if (out_tready) begin
          state_nxt = last_r ? pft_pkg::ST_IDLE : pft_pkg::ST_TEST;
        end
      end
      default: state_nxt = pft_pkg::ST_IDLE;
    endcase
  end

  // Handshake and divider control.
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      pft_pkg::ST_IDLE: in_tready  = 1'b1;
      pft_pkg::ST_TEST: div_start  = sq_le;
      pft_pkg::ST_DIV:  div_start  = 1'b0;
      pft_pkg::ST_SEND: out_tvalid = 1'b1;
      default:          in_tready  = 1'b0;
    endcase
  end

  // Datapath updates.
  always_comb begin
    rest_nxt    = rest_r;
    d_nxt       = d_r;
    sq_nxt      = sq_r;
    n_nxt       = n_r;
    factor_nxt  = factor_r;
    last_nxt    = last_r;
    invalid_nxt = invalid_r;
    case (state_r)
      pft_pkg::ST_IDLE: begin
        if (in_acc) begin
          rest_nxt    = in_tdata[VW-1:0];
          d_nxt       = VW'(2);
          sq_nxt      = (VW + 1)'(4);
          n_nxt       = '0;
          factor_nxt  = '0;
          last_nxt    = 1'b1;
          invalid_nxt = 1'b1;
        end
      end
      pft_pkg::ST_TEST: begin
        // Loop over: whatever is left above one is the final prime.
        if (!sq_le) begin
          factor_nxt  = rest_ext[FW-1:0];
          last_nxt    = 1'b1;
          invalid_nxt = 1'b0;
        end
      end
      pft_pkg::ST_DIV: begin
        if (div_done) begin
          if (rem_zero) begin
            // The divisor divides: emit it and divide it out, then try it again.
            rest_nxt    = div_quo;
            factor_nxt  = d_ext[FW-1:0];
            last_nxt    = (div_quo == VW'(1)) ||
                          (n_r == pft_pkg::CNT_W'(pft_pkg::MAX_RESULTS - 1));
            invalid_nxt = 1'b0;
            n_nxt       = n_r + 1'b1;
          end else begin
            // (d + 1)^2 = d^2 + 2d + 1.
            d_nxt  = d_r + 1'b1;
            sq_nxt = sq_r + {d_r, 1'b1};
          end
        end
      end
      pft_pkg::ST_SEND: begin
        factor_nxt = factor_r;
      end
      default: begin
        factor_nxt = factor_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r    <= rest_nxt;
    d_r       <= d_nxt;
    sq_r      <= sq_nxt;
    n_r       <= n_nxt;
    factor_r  <= factor_nxt;
    last_r    <= last_nxt;
    invalid_r <= invalid_nxt;
  end

  assign out_tdata = factor_r;
  assign out_tlast = last_r;
  assign out_tuser = invalid_r;

  // Results are never offered while a new item can be taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("result offered while input is open");

  // An invalid result is the only one for its item and carries factor zero.
  a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && (out_tdata == '0)))
    else $error("invalid result malformed");

  // After an item is taken the block stays busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened right after accept");

  // A valid factor is never below two when values fit the factor field.
  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser && (VW <= FW)) |-> (out_tdata > FW'(1)))
    else $error("factor below two");

endmodule
`default_nettype wire
